// ===== sv/pli_pkg.sv =====
// Types and command/status codes for the piecewise-linear interpolator.
// No dependencies; used by the top level, piecewise_linear_interpolator.
`timescale 1ns / 1ps
package pli_pkg;
   // table depth is bounded by the 7-bit point count of the response
   localparam int TABLE_DEPTH = 64;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;
   localparam logic [1:0] CMD_COUNT  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key_param;
      logic signed [31:0] range_end;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [6:0]         point_count;
   } rsp_type;
endpackage

// ===== sv/piecewise_linear_interpolator.sv =====
// Piecewise-linear interpolation table over 3-D Q16.16 points, top level.
// Depends on pli_pkg, pli_ram and pli_div.
`timescale 1ns / 1ps
// One request is handled at a time; req_stall is high from acceptance until the
// response is taken. Clear goes straight to the response, and append reads the
// last stored parameter before it writes. Count walks the parameter RAM one
// entry a cycle. Evaluate does the same linear walk until it finds the upper
// bracket point at index k, reads both end points, then runs a one-bit-per-cycle
// divider and three axis multiplies through one shared multiplier, or answers
// with a range status when t has no bracket. The block returns to idle after
// each response before it accepts the next request. The shared RAM port and
// the serial divider set the pace.
module piecewise_linear_interpolator #(
   parameter int FRAC_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pli_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pli_pkg::rsp_type rsp_data
);
   import pli_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_APRD  = 4'd1;
   localparam logic [3:0] S_APCHK = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_SCANW = 4'd4;
   localparam logic [3:0] S_RDLO  = 4'd5;
   localparam logic [3:0] S_RDHI  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_MUL   = 4'd8;
   localparam logic [3:0] S_ADD   = 4'd9;
   localparam logic [3:0] S_RESP  = 4'd10;
   localparam logic [3:0] S_DIVW  = 4'd11;

   logic [3:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] hit_ff, hit_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          pend_ff, pend_in;   // a read of idx_ff - 1 is in flight
   logic [1:0]    axis_ff, axis_in;
   logic signed [31:0] plo_ff, plo_in;
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] lo_in [3];
   logic signed [31:0] hi_ff [3];
   logic signed [31:0] hi_in [3];
   logic signed [31:0] phi_ff, phi_in;
   logic signed [64:0] prod_ff, prod_in;
   logic [FRAC_BITS-1:0] alpha_ff, alpha_in;

   logic          wr_en;
   logic [AW-1:0] addr;
   logic [31:0]   rd_p, rd_x, rd_y, rd_z;
   logic          div_start, div_done;
   logic [FRAC_BITS-1:0] div_q;
   logic signed [32:0] mdelta;
   logic signed [64:0] mprod;
   logic signed [64:0] shifted;

   pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_p (
      .clock, .wr_en, .addr, .wr_data(req_ff.key_param), .rd_data(rd_p));
   pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_x (
      .clock, .wr_en, .addr, .wr_data(req_ff.value_x), .rd_data(rd_x));
   pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_y (
      .clock, .wr_en, .addr, .wr_data(req_ff.value_y), .rd_data(rd_y));
   pli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram_z (
      .clock, .wr_en, .addr, .wr_data(req_ff.value_z), .rd_data(rd_z));

   pli_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock, .reset, .start(div_start),
      .off(32'(req_ff.key_param - plo_ff)), .span(32'(phi_ff - plo_ff)),
      .done(div_done), .quotient(div_q));

   // shared multiplier: (b - a) * alpha for the selected axis
   assign mdelta  = 33'(hi_ff[axis_ff]) - 33'(lo_ff[axis_ff]);
   assign mprod   = 65'(mdelta) * $signed({1'b0, alpha_ff});
   // arithmetic shift is floor division by 2^FRAC_BITS
   assign shifted = prod_ff >>> FRAC_BITS;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      cnt_in   = cnt_ff;
      pend_in  = 1'b0;
      axis_in  = axis_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      alpha_in = alpha_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      wr_en    = 1'b0;
      addr     = idx_ff[AW-1:0];
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               idx_in = '0;
               cnt_in = '0;
               hit_in = count_ff;
               case (req_data.command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  CMD_APPEND: begin
                     idx_in   = count_ff - NW'(1);
                     state_in = S_APRD;
                  end
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_APRD: state_in = S_APCHK;   // read of last parameter in flight
         S_APCHK: begin
            if (count_ff == NW'(TABLE_DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else if (count_ff != '0 && req_ff.key_param <= $signed(rd_p)) begin
               rsp_in.status = ST_ORDER;
            end else begin
               wr_en    = 1'b1;
               addr     = count_ff[AW-1:0];
               count_in = count_ff + NW'(1);
            end
            rsp_in.point_count = 7'(count_in);
            state_in = S_RESP;
         end
         S_SCAN: begin
            // issue read of idx, evaluate the one issued last cycle
            if (pend_ff) begin
               if (req_ff.command == CMD_COUNT) begin
                  if ($signed(rd_p) >= req_ff.key_param &&
                      $signed(rd_p) <= req_ff.range_end) begin
                     cnt_in = cnt_ff + 7'd1;
                  end
               end else if ($signed(rd_p) > req_ff.key_param) begin
                  hit_in   = idx_ff - NW'(1);
                  phi_in   = rd_p;
                  state_in = S_SCANW;
               end
            end
            if (state_in == S_SCAN) begin
               if (idx_ff < count_ff) begin
                  pend_in = 1'b1;
                  idx_in  = idx_ff + NW'(1);
               end else begin
                  state_in = S_SCANW;
               end
            end
         end
         S_SCANW: begin
            if (req_ff.command == CMD_COUNT) begin
               rsp_in.point_count = cnt_ff;
               state_in = S_RESP;
            end else if (hit_ff >= count_ff || hit_ff == '0) begin
               rsp_in.status      = ST_RANGE;
               rsp_in.point_count = 7'(count_ff);
               state_in = S_RESP;
            end else begin
               addr     = hit_ff[AW-1:0];
               state_in = S_RDHI;
            end
         end
         S_RDHI: begin
            hi_in[0] = rd_x;
            hi_in[1] = rd_y;
            hi_in[2] = rd_z;
            addr     = AW'(hit_ff - NW'(1));
            state_in = S_RDLO;
         end
         S_RDLO: begin
            lo_in[0] = rd_x;
            lo_in[1] = rd_y;
            lo_in[2] = rd_z;
            plo_in   = rd_p;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               alpha_in = div_q;
               axis_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mprod;
            state_in = S_ADD;
         end
         S_ADD: begin
            case (axis_ff)
               2'd0:    rsp_in.out_x = 32'(65'(lo_ff[0]) + shifted);
               2'd1:    rsp_in.out_y = 32'(65'(lo_ff[1]) + shifted);
               default: rsp_in.out_z = 32'(65'(lo_ff[2]) + shifted);
            endcase
            if (axis_ff == 2'd2) begin
               rsp_in.point_count = 7'(count_ff);
               state_in = S_RESP;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      cnt_ff   <= cnt_in;
      axis_ff  <= axis_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      prod_ff  <= prod_in;
      alpha_ff <= alpha_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end
endmodule

// ===== sv/pli_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== sv/pli_div.sv =====
// Restoring divider, one quotient bit per cycle: low FRAC_BITS bits of floor((off << FRAC_BITS) / span).
// No package dependencies.
`timescale 1ns / 1ps
module pli_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          off,
   input  logic [31:0]          span,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quotient
);
   localparam int QW = 32 + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] num_ff, num_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic [33:0]   diff;

   assign trial = {rem_ff, num_ff[QW-1]};
   assign diff  = {1'b0, trial} - {2'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = {off, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = span;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next numerator bit; quotient bit lands in num's LSB
         if (!diff[33]) begin
            rem_in = diff[31:0];
         end else begin
            rem_in = trial[31:0];
         end
         num_in = {num_ff[QW-2:0], ~diff[33]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff[FRAC_BITS-1:0];
endmodule
